// File: src/sv2dg_pkg.sv
// sv2dg_pkg: constants and widths shared by the signed value to decimal glyph converter
// no dependencies; imported by signed_value_to_decimal_glyphs_top
package sv2dg_pkg;

   // beat widths
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 40;

   // field widths
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned MODE_W  = 7;
   localparam int unsigned GLYPH_W = 6;
   localparam int unsigned DIGIT_W = 4;

   // pipeline depth, input register through result register
   localparam int unsigned NUM_STAGES = 5;

   // ascii marks for the sign
   localparam logic [MODE_W-1:0] MODE_CHARGE    = 7'd99;
   localparam logic [MODE_W-1:0] MODE_DISCHARGE = 7'd100;

   // glyph codes
   localparam logic [GLYPH_W-1:0] GLYPH_BASE  = 6'd32;
   localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 6'd42;

   // reciprocal of 100 for 16-bit values, rounded down, scaled by 2^22
   localparam logic [15:0] RECIP_100     = 16'd41943;
   localparam int unsigned RECIP_100_SH = 22;

   // result beat payload
   typedef struct packed {
      logic [GLYPH_W-1:0] glyph_units;
      logic [GLYPH_W-1:0] glyph_tens;
      logic [GLYPH_W-1:0] glyph_hundreds;
      logic [GLYPH_W-1:0] glyph_thousands;
      logic [GLYPH_W-1:0] glyph_ten_thousands;
      logic [MODE_W-1:0]  mode_char;
   } rsp_fields_type;

   // digit to glyph code
   function automatic logic [GLYPH_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] digit);
      digit_glyph = GLYPH_BASE + {2'b00, digit};
   endfunction

endpackage

// File: src/signed_value_to_decimal_glyphs_top.sv
// signed_value_to_decimal_glyphs_top: signed reading to mark and five decimal glyphs
// depends on sv2dg_pkg
//
// usage
//   req channel: one beat carries one signed 16-bit current reading in req_tdata[15:0]
//   rsp channel: one beat carries the sign mark ('c' for zero or positive, 'd' for
//     negative) and five glyph codes for the magnitude times 4, kept to 16 bits
//   glyph code is 32 plus the digit; the two top places show 42 while that place
//     and all higher places are zero
//   path: an accepted req beat passes the input, stage 1, stage 2, stage 3 and result registers
//   throughput: one beat per cycle; five register stages (input, reciprocal
//     multiply by 1/100, remainder fix-up, hundreds split, digit split) each hold
//     one reading, so a new reading enters every cycle the pipe moves
//   stall: when rsp_tready is low the result register holds its beat, stages
//     behind it keep filling any empty slot, and req_tready drops only once all
//     five stages are occupied
//   reset: synchronous, active high; empties every stage, no result is pending
module signed_value_to_decimal_glyphs_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sv2dg_pkg::REQ_DATA_W-1:0]   req_tdata,  // [15:0] current_value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [6:0] mode_char, [12:7] glyph_ten_thousands, [18:13] glyph_thousands,
   // [24:19] glyph_hundreds, [30:25] glyph_tens, [36:31] glyph_units, [39:37] zero
   output logic [sv2dg_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import sv2dg_pkg::*;

   // stage valid flags and move enables
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] adv;

   // stage 0: input register
   logic [VALUE_W-1:0] raw_ff;

   // stage 1: scaled value and quotient estimate
   logic               s1_neg_ff;
   logic [VALUE_W-1:0] s1_val_ff, s1_val_in;
   logic [9:0]         s1_qe_ff, s1_qe_in;
   logic [VALUE_W-1:0] s1_mag;
   logic [31:0]        s1_prod;

   // stage 2: value / 100 and value % 100
   logic       s2_neg_ff;
   logic [9:0] s2_hi_ff, s2_hi_in;
   logic [6:0] s2_lo_ff, s2_lo_in;
   logic [16:0] s2_q100;
   logic [16:0] s2_rem;

   // stage 3: ten-thousands digit, hundreds remainder, low two digits
   logic               s3_neg_ff;
   logic [2:0]         s3_tt_ff, s3_tt_in;
   logic [6:0]         s3_hr_ff, s3_hr_in;
   logic [DIGIT_W-1:0] s3_lt_ff, s3_lt_in;
   logic [DIGIT_W-1:0] s3_lu_ff, s3_lu_in;
   logic [15:0]        s3_hp;
   logic [9:0]         s3_hsub;
   logic [14:0]        s3_lp;
   logic [6:0]         s3_lsub;

   // stage 4: result register
   rsp_fields_type     rsp_ff, rsp_in;
   logic [14:0]        s4_hp;
   logic [DIGIT_W-1:0] s4_th;
   logic [6:0]         s4_hsub;
   logic [DIGIT_W-1:0] s4_hu;

   // move enables, from the result side back to the input
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_tready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_fields_type)){1'b0}}, rsp_ff};

   // valid flags move with the data
   always_comb begin
      vld_in = vld_ff;
      if (adv[0]) begin
         vld_in[0] = req_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (adv[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1 logic: magnitude times 4, then multiply by reciprocal of 100
   always_comb begin
      s1_mag    = raw_ff[VALUE_W-1] ? (~raw_ff + 16'd1) : raw_ff;
      s1_val_in = {s1_mag[VALUE_W-3:0], 2'b00};
      s1_prod   = 32'(s1_val_in) * 32'(RECIP_100);
      s1_qe_in  = s1_prod[RECIP_100_SH +: 10];
   end

   // stage 2 logic: the estimate is low by at most one, fix it up
   always_comb begin
      s2_q100 = 17'(s1_qe_ff) * 17'd100;
      s2_rem  = {1'b0, s1_val_ff} - s2_q100;
      if (s2_rem >= 17'd100) begin
         s2_hi_in = s1_qe_ff + 10'd1;
         s2_lo_in = 7'(s2_rem - 17'd100);
      end else begin
         s2_hi_in = s1_qe_ff;
         s2_lo_in = s2_rem[6:0];
      end
   end

   // stage 3 logic: split the quotient by 100 and the remainder by 10
   always_comb begin
      s3_hp    = 16'(s2_hi_ff) * 16'd41;
      s3_tt_in = s3_hp[14:12];
      s3_hsub  = s2_hi_ff - 10'(s3_tt_in) * 10'd100;
      s3_hr_in = s3_hsub[6:0];
      s3_lp    = 15'(s2_lo_ff) * 15'd205;
      s3_lt_in = s3_lp[14:11];
      s3_lsub  = s2_lo_ff - 7'(s3_lt_in) * 7'd10;
      s3_lu_in = s3_lsub[DIGIT_W-1:0];
   end

   // stage 4 logic: thousands and hundreds digits, blanking, glyph codes
   always_comb begin
      s4_hp   = 15'(s3_hr_ff) * 15'd205;
      s4_th   = s4_hp[14:11];
      s4_hsub = s3_hr_ff - 7'(s4_th) * 7'd10;
      s4_hu   = s4_hsub[DIGIT_W-1:0];

      rsp_in.mode_char = s3_neg_ff ? MODE_DISCHARGE : MODE_CHARGE;
      rsp_in.glyph_ten_thousands = (s3_tt_ff == 3'd0) ? GLYPH_BLANK
                                                      : digit_glyph({1'b0, s3_tt_ff});
      rsp_in.glyph_thousands = (s3_tt_ff == 3'd0 && s4_th == 4'd0) ? GLYPH_BLANK
                                                      : digit_glyph(s4_th);
      rsp_in.glyph_hundreds = digit_glyph(s4_hu);
      rsp_in.glyph_tens     = digit_glyph(s3_lt_ff);
      rsp_in.glyph_units    = digit_glyph(s3_lu_ff);
   end

   // payload registers, loaded when their stage moves
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         raw_ff <= req_tdata[VALUE_W-1:0];
      end
      if (adv[1]) begin
         s1_neg_ff <= raw_ff[VALUE_W-1];
         s1_val_ff <= s1_val_in;
         s1_qe_ff  <= s1_qe_in;
      end
      if (adv[2]) begin
         s2_neg_ff <= s1_neg_ff;
         s2_hi_ff  <= s2_hi_in;
         s2_lo_ff  <= s2_lo_in;
      end
      if (adv[3]) begin
         s3_neg_ff <= s2_neg_ff;
         s3_tt_ff  <= s3_tt_in;
         s3_hr_ff  <= s3_hr_in;
         s3_lt_ff  <= s3_lt_in;
         s3_lu_ff  <= s3_lu_in;
      end
      if (adv[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   // a pipe with no reading in flight always takes a beat
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (vld_ff == '0) |-> req_tready)
      else $error("pipe empty but req_tready low");

   // mark is one of the two sign characters
   a_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_ff.mode_char == MODE_CHARGE || rsp_ff.mode_char == MODE_DISCHARGE))
      else $error("bad mode mark");

   // a shown ten-thousands digit implies a shown thousands digit
   a_blank_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.glyph_ten_thousands != GLYPH_BLANK)
      |-> rsp_ff.glyph_thousands != GLYPH_BLANK)
      else $error("thousands blanked under a shown ten-thousands digit");

   // remainder after the fix-up stays a two-digit value and the quotient stays below 656
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (s2_lo_ff < 7'd100 && s2_hi_ff < 10'd656))
      else $error("divide by 100 fix-up out of range");

endmodule
